// ----- hdl/midpoint_ellipse_raster_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint ellipse rasteriser
// Same-cycle and next-cycle implication checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTER_ASSERT_SVH

`ifndef SYNTHESIS
`define MER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MER_ASSERT_NOW(label, ante, cons, msg)
`define MER_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/mer_pkg.sv -----
// ----------------------------------------------------------------------------
// Midpoint ellipse rasteriser package
// Command and status types between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mer_pkg;

    // Input word action codes.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_EMIT  = 1'b1;

    // Shared multiplier operand selection.
    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_AA   = 3'd1;
    localparam logic [2:0] MUL_BB   = 3'd2;
    localparam logic [2:0] MUL_A2B  = 3'd3;
    localparam logic [2:0] MUL_BT   = 3'd4;
    localparam logic [2:0] MUL_SQ   = 3'd5;
    localparam logic [2:0] MUL_AY   = 3'd6;
    localparam logic [2:0] MUL_AB   = 3'd7;

    // Decision register operations.
    localparam logic [2:0] D_HOLD  = 3'd0;
    localparam logic [2:0] D_INIT  = 3'd1;
    localparam logic [2:0] D_STEP  = 3'd2;
    localparam logic [2:0] D_LOAD  = 3'd3;
    localparam logic [2:0] D_ADD4  = 3'd4;
    localparam logic [2:0] D_ENTER = 3'd5;

    typedef struct packed {
        logic       load_start;
        logic [2:0] mul_op;
        logic       ld_asq;
        logic       ld_bsq;
        logic [2:0] d_op;
        logic       clear_active;
        logic       load_out;
        logic       out_zero;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic second_region;
        logic stay;
        logic y_neg;
        logic out_free;
    } status_t;

endpackage

// ----- hdl/mer_ctrl.sv -----
// ----------------------------------------------------------------------------
// Midpoint ellipse rasteriser controller
// Sequences set-up, stepping, region change and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mer_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             action,
    input  mer_pkg::status_t status,
    output mer_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MAA    = 4'd1;
    localparam logic [3:0] S_MBB    = 4'd2;
    localparam logic [3:0] S_MA2B   = 4'd3;
    localparam logic [3:0] S_INIT   = 4'd4;
    localparam logic [3:0] S_SETTLE = 4'd5;
    localparam logic [3:0] S_STEP   = 4'd6;
    localparam logic [3:0] S_EN0    = 4'd7;
    localparam logic [3:0] S_EN1    = 4'd8;
    localparam logic [3:0] S_EN2    = 4'd9;
    localparam logic [3:0] S_EN3    = 4'd10;
    localparam logic [3:0] S_EN4    = 4'd11;
    localparam logic [3:0] S_EN5    = 4'd12;
    localparam logic [3:0] S_EN6    = 4'd13;
    localparam logic [3:0] S_OUTPUT = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       start_pend_reg;
    logic       start_pend_next;
    logic       zero_pend_reg;
    logic       zero_pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_pend_reg <= 1'b0;
            zero_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            start_pend_reg <= start_pend_next;
            zero_pend_reg  <= zero_pend_next;
        end
    end

    always_comb
    begin
        cmd             = '0;
        in_ready        = 1'b0;
        state_next      = state_reg;
        start_pend_next = start_pend_reg;
        zero_pend_next  = zero_pend_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (action == mer_pkg::ACT_START)
                    begin
                        cmd.load_start  = 1'b1;
                        start_pend_next = 1'b1;
                        state_next      = S_MAA;
                    end
                    else if (status.active)
                    begin
                        cmd.d_op   = mer_pkg::D_STEP;
                        state_next = S_SETTLE;
                    end
                    else
                    begin
                        zero_pend_next = 1'b1;
                        state_next     = S_OUTPUT;
                    end
                end
            end
            S_MAA:
            begin
                cmd.mul_op = mer_pkg::MUL_AA;
                state_next = S_MBB;
            end
            S_MBB:
            begin
                cmd.mul_op = mer_pkg::MUL_BB;
                cmd.ld_asq = 1'b1;
                state_next = S_MA2B;
            end
            S_MA2B:
            begin
                cmd.mul_op = mer_pkg::MUL_A2B;
                cmd.ld_bsq = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.d_op   = mer_pkg::D_INIT;
                state_next = S_SETTLE;
            end
            S_SETTLE:
            begin
                if (!status.second_region && !status.stay)
                begin
                    state_next = S_EN0;
                end
                else
                begin
                    cmd.clear_active = status.second_region && status.y_neg;
                    if (start_pend_reg)
                    begin
                        state_next = S_STEP;
                    end
                    else if (status.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_OUTPUT;
                    end
                end
            end
            S_STEP:
            begin
                cmd.d_op        = mer_pkg::D_STEP;
                start_pend_next = 1'b0;
                state_next      = S_SETTLE;
            end
            S_EN0:
            begin
                cmd.mul_op = mer_pkg::MUL_BT;
                state_next = S_EN1;
            end
            S_EN1:
            begin
                cmd.mul_op = mer_pkg::MUL_SQ;
                state_next = S_EN2;
            end
            S_EN2:
            begin
                cmd.d_op   = mer_pkg::D_LOAD;
                cmd.mul_op = mer_pkg::MUL_AY;
                state_next = S_EN3;
            end
            S_EN3:
            begin
                cmd.mul_op = mer_pkg::MUL_SQ;
                state_next = S_EN4;
            end
            S_EN4:
            begin
                cmd.d_op   = mer_pkg::D_ADD4;
                cmd.mul_op = mer_pkg::MUL_AB;
                state_next = S_EN5;
            end
            S_EN5:
            begin
                cmd.mul_op = mer_pkg::MUL_SQ;
                state_next = S_EN6;
            end
            S_EN6:
            begin
                cmd.d_op   = mer_pkg::D_ENTER;
                state_next = S_SETTLE;
            end
            S_OUTPUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_zero   = zero_pend_reg;
                    zero_pend_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/mer_dpath.sv -----
// ----------------------------------------------------------------------------
// Midpoint ellipse rasteriser datapath
// Geometry registers, shared multiplier, decision updates and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mer_dpath #(
    parameter int COORD_BITS = 12,
    parameter int AXIS_BITS  = 11
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [AXIS_BITS-1:0]          axis_a,
    input  logic [AXIS_BITS-1:0]          axis_b,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  mer_pkg::cmd_t                 cmd,
    output mer_pkg::status_t              status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          valid_res,
    output logic                          last,
    output logic signed [COORD_BITS+1:0]  px_pp,
    output logic signed [COORD_BITS+1:0]  py_pp,
    output logic signed [COORD_BITS+1:0]  px_mm,
    output logic signed [COORD_BITS+1:0]  py_mm,
    output logic signed [COORD_BITS+1:0]  px_pm,
    output logic signed [COORD_BITS+1:0]  py_pm,
    output logic signed [COORD_BITS+1:0]  px_mp,
    output logic signed [COORD_BITS+1:0]  py_mp,
    output logic [23:0]                   pixel_color
);

    localparam int X_W   = AXIS_BITS + 1;
    localparam int Y_W   = AXIS_BITS + 2;
    localparam int SQ_W  = 2 * AXIS_BITS;
    localparam int M_W   = 2 * AXIS_BITS + 2;
    localparam int P_W   = 2 * M_W;
    localparam int DEC_W = 4 * AXIS_BITS + 8;
    localparam int OUT_W = COORD_BITS + 2;

    logic [COORD_BITS-1:0]   held_cx_reg;
    logic [COORD_BITS-1:0]   held_cy_reg;
    logic [AXIS_BITS-1:0]    held_a_reg;
    logic [AXIS_BITS-1:0]    held_b_reg;
    logic [23:0]             held_color_reg;
    logic [SQ_W-1:0]         a_sq_reg;
    logic [SQ_W-1:0]         b_sq_reg;
    logic [P_W-1:0]          prod_reg;
    logic [P_W-1:0]          prod_next;
    logic signed [DEC_W-1:0] dec_reg;
    logic signed [DEC_W-1:0] ex_reg;
    logic signed [DEC_W-1:0] gx_reg;
    logic signed [DEC_W-1:0] ey_reg;
    logic signed [DEC_W-1:0] hy_reg;
    logic signed [DEC_W-1:0] ll_reg;
    logic signed [DEC_W-1:0] rr_reg;
    logic [X_W-1:0]          x_reg;
    logic signed [Y_W-1:0]   y_reg;
    logic [X_W-1:0]          x_pt_reg;
    logic signed [Y_W-1:0]   y_pt_reg;
    logic                    active_reg;
    logic                    second_reg;
    logic                    out_valid_reg;

    logic signed [DEC_W-1:0] as_w;
    logic signed [DEC_W-1:0] bs_w;
    logic signed [DEC_W-1:0] pr_w;
    logic signed [DEC_W-1:0] step_d;
    logic                    dec_le;
    logic                    x_inc;
    logic                    y_dec;
    logic [X_W:0]            t_w;
    logic signed [Y_W-1:0]   ym1;
    logic [Y_W-1:0]          ymag;
    logic [M_W-1:0]          op_a;
    logic [M_W-1:0]          op_b;
    logic [OUT_W-1:0]        cx_o;
    logic [OUT_W-1:0]        cy_o;
    logic [OUT_W-1:0]        x_o;
    logic [OUT_W-1:0]        y_o;

    assign as_w = DEC_W'(a_sq_reg);
    assign bs_w = DEC_W'(b_sq_reg);
    assign pr_w = DEC_W'(prod_reg);

    // Midpoint at or inside the ellipse.
    assign dec_le = dec_reg[DEC_W-1] || (dec_reg == {DEC_W{1'b0}});

    always_comb
    begin
        if (!second_reg)
        begin
            x_inc  = 1'b1;
            y_dec  = !dec_le;
            step_d = dec_reg + ex_reg - (dec_le ? {DEC_W{1'b0}} : ey_reg);
        end
        else
        begin
            x_inc  = dec_le;
            y_dec  = 1'b1;
            step_d = dec_reg - hy_reg + (dec_le ? gx_reg : {DEC_W{1'b0}});
        end
    end

    // Operands for the region-two entry value.
    assign t_w  = {x_reg, 1'b1};
    assign ym1  = y_reg + $signed({Y_W{1'b1}});
    assign ymag = ym1[Y_W-1] ? (~ym1 + {{(Y_W-1){1'b0}}, 1'b1}) : ym1;

    always_comb
    begin
        case (cmd.mul_op)
            mer_pkg::MUL_AA:
            begin
                op_a = M_W'(held_a_reg);
                op_b = M_W'(held_a_reg);
            end
            mer_pkg::MUL_BB:
            begin
                op_a = M_W'(held_b_reg);
                op_b = M_W'(held_b_reg);
            end
            mer_pkg::MUL_A2B:
            begin
                op_a = M_W'(a_sq_reg);
                op_b = M_W'(held_b_reg);
            end
            mer_pkg::MUL_BT:
            begin
                op_a = M_W'(held_b_reg);
                op_b = M_W'(t_w);
            end
            mer_pkg::MUL_SQ:
            begin
                op_a = prod_reg[M_W-1:0];
                op_b = prod_reg[M_W-1:0];
            end
            mer_pkg::MUL_AY:
            begin
                op_a = M_W'(held_a_reg);
                op_b = M_W'(ymag);
            end
            mer_pkg::MUL_AB:
            begin
                op_a = M_W'(held_a_reg);
                op_b = M_W'(held_b_reg);
            end
            default:
            begin
                op_a = {M_W{1'b0}};
                op_b = {M_W{1'b0}};
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            held_cx_reg    <= center_x;
            held_cy_reg    <= center_y;
            held_a_reg     <= axis_a;
            held_b_reg     <= axis_b;
            held_color_reg <= {red, green, blue};
        end
        if (cmd.mul_op != mer_pkg::MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.ld_asq)
        begin
            a_sq_reg <= prod_reg[SQ_W-1:0];
        end
        if (cmd.ld_bsq)
        begin
            b_sq_reg <= prod_reg[SQ_W-1:0];
        end
        case (cmd.d_op)
            mer_pkg::D_INIT:
            begin
                // prod_reg holds a^2 * b here.
                dec_reg <= (bs_w <<< 2) + as_w - (pr_w <<< 2);
                ey_reg  <= (pr_w <<< 3) - (as_w <<< 3);
                hy_reg  <= (pr_w <<< 3) - (as_w <<< 3) - (as_w <<< 2);
                rr_reg  <= (pr_w <<< 1) - as_w;
                ex_reg  <= (bs_w <<< 3) + (bs_w <<< 2);
                gx_reg  <= bs_w <<< 3;
                ll_reg  <= bs_w <<< 1;
                x_reg   <= {X_W{1'b0}};
                y_reg   <= Y_W'(held_b_reg);
            end
            mer_pkg::D_STEP:
            begin
                dec_reg  <= step_d;
                x_pt_reg <= x_reg;
                y_pt_reg <= y_reg;
                if (x_inc)
                begin
                    x_reg  <= x_reg + {{(X_W-1){1'b0}}, 1'b1};
                    ex_reg <= ex_reg + (bs_w <<< 3);
                    gx_reg <= gx_reg + (bs_w <<< 3);
                    ll_reg <= ll_reg + (bs_w <<< 1);
                end
                if (y_dec)
                begin
                    y_reg  <= ym1;
                    ey_reg <= ey_reg - (as_w <<< 3);
                    hy_reg <= hy_reg - (as_w <<< 3);
                    rr_reg <= rr_reg - (as_w <<< 1);
                end
            end
            mer_pkg::D_LOAD:
            begin
                dec_reg <= pr_w;
            end
            mer_pkg::D_ADD4:
            begin
                dec_reg <= dec_reg + (pr_w <<< 2);
            end
            mer_pkg::D_ENTER:
            begin
                dec_reg <= dec_reg - (pr_w <<< 2);
            end
            default:
            begin
                dec_reg <= dec_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.d_op == mer_pkg::D_INIT)
            begin
                active_reg <= 1'b1;
                second_reg <= 1'b0;
            end
            else if (cmd.d_op == mer_pkg::D_ENTER)
            begin
                second_reg <= 1'b1;
            end
            if (cmd.clear_active)
            begin
                active_reg <= 1'b0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Coordinates wrap to the output width.
    assign cx_o = OUT_W'(held_cx_reg);
    assign cy_o = OUT_W'(held_cy_reg);
    assign x_o  = OUT_W'(x_pt_reg);
    assign y_o  = OUT_W'(y_pt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (cmd.out_zero)
            begin
                valid_res   <= 1'b0;
                last        <= 1'b0;
                px_pp       <= {OUT_W{1'b0}};
                py_pp       <= {OUT_W{1'b0}};
                px_mm       <= {OUT_W{1'b0}};
                py_mm       <= {OUT_W{1'b0}};
                px_pm       <= {OUT_W{1'b0}};
                py_pm       <= {OUT_W{1'b0}};
                px_mp       <= {OUT_W{1'b0}};
                py_mp       <= {OUT_W{1'b0}};
                pixel_color <= 24'd0;
            end
            else
            begin
                valid_res   <= 1'b1;
                last        <= !active_reg || cmd.clear_active;
                px_pp       <= cx_o + x_o;
                py_pp       <= cy_o + y_o;
                px_mm       <= cx_o - x_o;
                py_mm       <= cy_o - y_o;
                px_pm       <= cx_o + x_o;
                py_pm       <= cy_o - y_o;
                px_mp       <= cx_o - x_o;
                py_mp       <= cy_o + y_o;
                pixel_color <= held_color_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;

    assign status.active        = active_reg;
    assign status.second_region = second_reg;
    assign status.stay          = !y_reg[Y_W-1] && (y_reg != {Y_W{1'b0}})
                                  && (ll_reg < rr_reg);
    assign status.y_neg         = y_reg[Y_W-1];
    assign status.out_free      = !out_valid_reg || out_ready;

endmodule

// ----- hdl/midpoint_ellipse_raster.sv -----
// ----------------------------------------------------------------------------
// Midpoint ellipse rasteriser, top level
// Axis-aligned ellipse outline generator with four-way symmetric output.
// ----------------------------------------------------------------------------
// A start word (action 0) loads the centre, the two semi-axes and the colour
// and returns the first group of four mirrored points; every emit word
// (action 1) returns the next group, and an emit word with no ellipse in
// progress returns a word with valid_res low and every field zero. Points on
// the axes appear twice, and last marks the final group. An emit word on a
// running ellipse is stepped once before its result is loaded; when that
// step crosses from region one into region two, the region-two decision
// value is first built with six passes through the single shared
// multiplier, and the region test is made once more afterwards. A start
// word makes three multiplier passes for the squares and a^2*b, then one
// step, plus that region-two build when it meets the region change. One
// word is worked on at a time; the next is taken as soon as the previous
// result sits in the output register, even if that result has not yet been
// taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "midpoint_ellipse_raster_assert.svh"

module midpoint_ellipse_raster #(
    parameter int COORD_BITS = 12,
    parameter int AXIS_BITS  = 11
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input words
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [AXIS_BITS-1:0]          axis_a,
    input  logic [AXIS_BITS-1:0]          axis_b,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    // Result words
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          valid_res,
    output logic                          last,
    output logic signed [COORD_BITS+1:0]  px_pp,
    output logic signed [COORD_BITS+1:0]  py_pp,
    output logic signed [COORD_BITS+1:0]  px_mm,
    output logic signed [COORD_BITS+1:0]  py_mm,
    output logic signed [COORD_BITS+1:0]  px_pm,
    output logic signed [COORD_BITS+1:0]  py_pm,
    output logic signed [COORD_BITS+1:0]  px_mp,
    output logic signed [COORD_BITS+1:0]  py_mp,
    output logic [23:0]                   pixel_color
);

    mer_pkg::cmd_t    cmd;
    mer_pkg::status_t status;

    // The controller owns the sequence; the datapath holds the geometry, the
    // incremental decision terms and the output register.
    mer_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    mer_dpath #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS)
    ) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .center_x    (center_x),
        .center_y    (center_y),
        .axis_a      (axis_a),
        .axis_b      (axis_b),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .valid_res   (valid_res),
        .last        (last),
        .px_pp       (px_pp),
        .py_pp       (py_pp),
        .px_mm       (px_mm),
        .py_mm       (py_mm),
        .px_pm       (px_pm),
        .py_pm       (py_pm),
        .px_mp       (px_mp),
        .py_mp       (py_mp),
        .pixel_color (pixel_color)
    );

    // A result is only written into an empty or draining output register.
    `MER_ASSERT_NOW(a_load_free, cmd.load_out, (!out_valid || out_ready), "result overwritten")
    // Every accepted word takes the controller out of its waiting state.
    `MER_ASSERT_NEXT(a_busy_after_accept, (in_valid && in_ready), !in_ready, "ready after accept")
    // The point stepper only runs on an ellipse in progress.
    `MER_ASSERT_NOW(a_step_active, (cmd.d_op == mer_pkg::D_STEP), status.active, "step when idle")
    // Region two is entered once per ellipse.
    `MER_ASSERT_NOW(a_enter_once, (cmd.d_op == mer_pkg::D_ENTER), !status.second_region,
        "second region entry repeated")

endmodule

// ----- tb/midpoint_ellipse_raster_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point group checker for the midpoint ellipse rasteriser
// Watches both channels, traces the ellipse in step with every accepted input
// word and compares each result word, field by field, with the oldest trace.
// ----------------------------------------------------------------------------
module midpoint_ellipse_raster_checker #(
    parameter int COORD_BITS = 12,
    parameter int AXIS_BITS  = 11
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          action,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [AXIS_BITS-1:0]          axis_a,
    input  logic [AXIS_BITS-1:0]          axis_b,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          valid_res,
    input  logic                          last,
    input  logic signed [COORD_BITS+1:0]  px_pp,
    input  logic signed [COORD_BITS+1:0]  py_pp,
    input  logic signed [COORD_BITS+1:0]  px_mm,
    input  logic signed [COORD_BITS+1:0]  py_mm,
    input  logic signed [COORD_BITS+1:0]  px_pm,
    input  logic signed [COORD_BITS+1:0]  py_pm,
    input  logic signed [COORD_BITS+1:0]  px_mp,
    input  logic signed [COORD_BITS+1:0]  py_mp,
    input  logic [23:0]                   pixel_color,
    output int                            error_count,
    output int                            pending,
    output int                            groups_seen,
    output int                            ellipses_done,
    output int                            idle_seen
);

    localparam int PW = COORD_BITS + 2;
    localparam int XW = AXIS_BITS + 1;

    typedef struct packed {
        logic          carries;
        logic          final_group;
        logic [PW-1:0] x_pp;
        logic [PW-1:0] y_pp;
        logic [PW-1:0] x_mm;
        logic [PW-1:0] y_mm;
        logic [PW-1:0] x_pm;
        logic [PW-1:0] y_pm;
        logic [PW-1:0] x_mp;
        logic [PW-1:0] y_mp;
        logic [23:0]   colour;
    } point_group_t;

    point_group_t expected_groups[$];
    point_group_t predicted;
    point_group_t observed;
    point_group_t oldest;

    // Tracer state, kept in step with the block.
    logic                  drawing;
    logic                  in_region_two;
    logic [XW-1:0]         off_x;
    int                    off_y;
    logic [63:0]           decision;
    logic [63:0]           a_sq;
    logic [63:0]           b_sq;
    logic [COORD_BITS-1:0] centre_x;
    logic [COORD_BITS-1:0] centre_y;
    logic [23:0]           colour;

    int mismatches;
    int groups;
    int finished;
    int idles;

    // Midpoint value at (x + 1/2, y - 1), scaled by four.
    function automatic logic [63:0] region_two_seed(logic [XW-1:0] x, int y,
                                                    logic [63:0] asq, logic [63:0] bsq);
        logic [63:0] t;
        logic [63:0] ya;
        int          ym1;
        t   = 64'(x);
        t   = 2 * t + 1;
        ym1 = y - 1;
        ya  = (ym1 < 0) ? 64'(-ym1) : 64'(ym1);
        return bsq * t * t + 4 * asq * ya * ya - 4 * asq * bsq;
    endfunction

    // Region one ends when its slope test fails; the ellipse ends below y = 0.
    task automatic check_region_exit();
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [63:0] xl;
        logic [63:0] yl;
        logic        stay;
        if (!in_region_two) begin
            stay = 1'b0;
            if (off_y >= 1) begin
                xl   = 64'(off_x);
                yl   = 64'(off_y);
                lhs  = 2 * b_sq * (xl + 1);
                rhs  = a_sq * (2 * yl - 1);
                stay = lhs < rhs;
            end
            if (!stay) begin
                in_region_two = 1'b1;
                decision      = region_two_seed(off_x, off_y, a_sq, b_sq);
            end
        end
        if (in_region_two && off_y < 0)
            drawing = 1'b0;
    endtask

    task automatic trace_word(input logic act,
                              input logic [COORD_BITS-1:0] cx,
                              input logic [COORD_BITS-1:0] cy,
                              input logic [AXIS_BITS-1:0] a,
                              input logic [AXIS_BITS-1:0] b,
                              input logic [23:0] rgb,
                              output point_group_t grp);
        logic [63:0] av;
        logic [63:0] bv;
        logic [63:0] xl;
        logic [63:0] yl;
        logic        le;
        logic        gt;
        grp = '0;
        if (act == mer_pkg::ACT_START) begin
            av            = 64'(a);
            bv            = 64'(b);
            centre_x      = cx;
            centre_y      = cy;
            a_sq          = av * av;
            b_sq          = bv * bv;
            colour        = rgb;
            off_x         = '0;
            off_y         = int'(b);
            in_region_two = 1'b0;
            decision      = 4 * b_sq + a_sq - 4 * a_sq * bv;
            drawing       = 1'b1;
            check_region_exit();
        end
        if (drawing) begin
            grp.carries = 1'b1;
            grp.x_pp    = PW'(centre_x) + PW'(off_x);
            grp.y_pp    = PW'(centre_y) + off_y[PW-1:0];
            grp.x_mm    = PW'(centre_x) - PW'(off_x);
            grp.y_mm    = PW'(centre_y) - off_y[PW-1:0];
            grp.x_pm    = PW'(centre_x) + PW'(off_x);
            grp.y_pm    = PW'(centre_y) - off_y[PW-1:0];
            grp.x_mp    = PW'(centre_x) - PW'(off_x);
            grp.y_mp    = PW'(centre_y) + off_y[PW-1:0];
            grp.colour  = colour;
            xl = 64'(off_x);
            yl = 64'(off_y);
            if (in_region_two) begin
                gt       = !decision[63] && decision != 0;
                decision = decision + 12 * a_sq - 8 * a_sq * yl;
                if (!gt) begin
                    decision = decision + 4 * b_sq * (2 * xl + 2);
                    off_x    = off_x + XW'(1);
                end
                off_y = off_y - 1;
            end else begin
                le       = decision[63] || decision == 0;
                decision = decision + 4 * b_sq * (2 * xl + 3);
                if (!le) begin
                    decision = decision - 8 * a_sq * (yl - 1);
                    off_y    = off_y - 1;
                end
                off_x = off_x + XW'(1);
            end
            check_region_exit();
            grp.final_group = !drawing;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            drawing       = 1'b0;
            in_region_two = 1'b0;
            off_x         = '0;
            off_y         = 0;
            decision      = '0;
            a_sq          = '0;
            b_sq          = '0;
            centre_x      = '0;
            centre_y      = '0;
            colour        = '0;
            mismatches    = 0;
            groups        = 0;
            finished      = 0;
            idles         = 0;
            expected_groups.delete();
            error_count   <= 0;
            pending       <= 0;
            groups_seen   <= 0;
            ellipses_done <= 0;
            idle_seen     <= 0;
        end else begin
            if (in_valid && in_ready) begin
                trace_word(action, center_x, center_y, axis_a, axis_b,
                           {red, green, blue}, predicted);
                expected_groups.push_back(predicted);
            end
            if (out_valid && out_ready) begin
                observed = {valid_res, last, px_pp, py_pp, px_mm, py_mm,
                            px_pm, py_pm, px_mp, py_mp, pixel_color};
                if (expected_groups.size() == 0) begin
                    $display("[%0t] result word with nothing expected: actual %0h",
                             $time, observed);
                    mismatches++;
                end else begin
                    oldest = expected_groups.pop_front();
                    compare_field("valid_res", 32'(oldest.carries), 32'(observed.carries));
                    compare_field("last", 32'(oldest.final_group),
                                  32'(observed.final_group));
                    compare_field("px_pp", 32'(oldest.x_pp), 32'(observed.x_pp));
                    compare_field("py_pp", 32'(oldest.y_pp), 32'(observed.y_pp));
                    compare_field("px_mm", 32'(oldest.x_mm), 32'(observed.x_mm));
                    compare_field("py_mm", 32'(oldest.y_mm), 32'(observed.y_mm));
                    compare_field("px_pm", 32'(oldest.x_pm), 32'(observed.x_pm));
                    compare_field("py_pm", 32'(oldest.y_pm), 32'(observed.y_pm));
                    compare_field("px_mp", 32'(oldest.x_mp), 32'(observed.x_mp));
                    compare_field("py_mp", 32'(oldest.y_mp), 32'(observed.y_mp));
                    compare_field("pixel_color", 32'(oldest.colour), 32'(observed.colour));
                    if (oldest.carries) begin
                        groups++;
                        if (oldest.final_group)
                            finished++;
                    end else begin
                        idles++;
                    end
                end
            end
            error_count   <= mismatches;
            pending       <= expected_groups.size();
            groups_seen   <= groups;
            ellipses_done <= finished;
            idle_seen     <= idles;
        end
    end

endmodule

// ----- tb/midpoint_ellipse_raster_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the midpoint ellipse rasteriser
// Drives start and emit words with random gaps and output stalls, and leaves
// prediction and comparison to the checker that sits beside the block.
// ----------------------------------------------------------------------------
module midpoint_ellipse_raster_tb;

    localparam int COORD_BITS   = 12;
    localparam int AXIS_BITS    = 11;
    localparam int RANDOM_WORDS = 1650;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          in_valid    = 1'b0;
    logic                          in_ready;
    logic                          action      = mer_pkg::ACT_START;
    logic [COORD_BITS-1:0]         center_x    = '0;
    logic [COORD_BITS-1:0]         center_y    = '0;
    logic [AXIS_BITS-1:0]          axis_a      = '0;
    logic [AXIS_BITS-1:0]          axis_b      = '0;
    logic [7:0]                    red         = '0;
    logic [7:0]                    green       = '0;
    logic [7:0]                    blue        = '0;
    logic                          out_valid;
    logic                          out_ready   = 1'b0;
    logic                          valid_res;
    logic                          last;
    logic signed [COORD_BITS+1:0]  px_pp;
    logic signed [COORD_BITS+1:0]  py_pp;
    logic signed [COORD_BITS+1:0]  px_mm;
    logic signed [COORD_BITS+1:0]  py_mm;
    logic signed [COORD_BITS+1:0]  px_pm;
    logic signed [COORD_BITS+1:0]  py_pm;
    logic signed [COORD_BITS+1:0]  px_mp;
    logic signed [COORD_BITS+1:0]  py_mp;
    logic [23:0]                   pixel_color;

    int error_count;
    int pending;
    int groups_seen;
    int ellipses_done;
    int idle_seen;

    int words_sent = 0;
    int calm_left  = 0;
    int stall_left = 0;
    int stall_pick;

    always #2 clk = ~clk;

    midpoint_ellipse_raster #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .center_x    (center_x),
        .center_y    (center_y),
        .axis_a      (axis_a),
        .axis_b      (axis_b),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .valid_res   (valid_res),
        .last        (last),
        .px_pp       (px_pp),
        .py_pp       (py_pp),
        .px_mm       (px_mm),
        .py_mm       (py_mm),
        .px_pm       (px_pm),
        .py_pm       (py_pm),
        .px_mp       (px_mp),
        .py_mp       (py_mp),
        .pixel_color (pixel_color)
    );

    midpoint_ellipse_raster_checker #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .center_x      (center_x),
        .center_y      (center_y),
        .axis_a        (axis_a),
        .axis_b        (axis_b),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .valid_res     (valid_res),
        .last          (last),
        .px_pp         (px_pp),
        .py_pp         (py_pp),
        .px_mm         (px_mm),
        .py_mm         (py_mm),
        .px_pm         (px_pm),
        .py_pm         (py_pm),
        .px_mp         (px_mp),
        .py_mp         (py_mp),
        .pixel_color   (pixel_color),
        .error_count   (error_count),
        .pending       (pending),
        .groups_seen   (groups_seen),
        .ellipses_done (ellipses_done),
        .idle_seen     (idle_seen)
    );

    // The result side holds ready in runs: long open stretches, short
    // flickers and the odd long stall, so that back-pressure lands on every
    // phase of the block's work, including the multi-pass region change.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 35) begin
                out_ready  <= 1'b1;
                stall_left = $urandom_range(20, 150);
            end else if (stall_pick < 75) begin
                out_ready  <= 1'b1;
                stall_left = $urandom_range(0, 5);
            end else if (stall_pick < 95) begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(15, 50);
            end
        end
    end

    // Gap before the next input word. Mostly none or a short one, now and then
    // a long pause, and every so often a calm run of back-to-back words.
    function automatic int next_gap();
        int pick;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            calm_left = $urandom_range(30, 100);
            return 0;
        end
        if (pick < 55)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Called just after a rising edge. Valid is raised with the payload and
    // then held, unchanged, until the edge at which the block takes the word.
    task automatic send_word(input logic act,
                             input logic [COORD_BITS-1:0] cx,
                             input logic [COORD_BITS-1:0] cy,
                             input logic [AXIS_BITS-1:0] a,
                             input logic [AXIS_BITS-1:0] b,
                             input logic [23:0] rgb);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        center_x <= cx;
        center_y <= cy;
        axis_a   <= a;
        axis_b   <= b;
        red      <= rgb[23:16];
        green    <= rgb[15:8];
        blue     <= rgb[7:0];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // Emit words carry random geometry and colour, which the block must ignore.
    task automatic emit_word();
        send_word(mer_pkg::ACT_EMIT, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  AXIS_BITS'($urandom), AXIS_BITS'($urandom), 24'($urandom));
    endtask

    task automatic draw(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                        input logic [AXIS_BITS-1:0] a, input logic [AXIS_BITS-1:0] b,
                        input logic [23:0] rgb, input int emits);
        send_word(mer_pkg::ACT_START, cx, cy, a, b, rgb);
        repeat (emits) emit_word();
    endtask

    // Axes are mostly small so that whole ellipses run to their final group
    // within the word budget; a few are larger to go deeper into region two.
    function automatic int small_axis();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return $urandom_range(0, 12);
        if (pick < 97)
            return $urandom_range(13, 40);
        return $urandom_range(41, 120);
    endfunction

    initial begin
        int kind;
        int a;
        int b;
        int emits;
        int random_start;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An emit before anything has started must give an
        // all-zero word; a zero-sized ellipse is a single point; a zero
        // horizontal axis gives a vertical line; a zero vertical axis gives
        // one group; the largest ellipse is abandoned by a restart, as is
        // each of the long narrow ones. Extra emits check the idle reply.
        emit_word();
        draw(0, 0, 0, 0, 24'h000000, 1);
        draw(4095, 4095, 0, 3, 24'hFFFFFF, 4);
        draw(100, 200, 5, 0, 24'h123456, 1);
        draw(4095, 0, 2047, 2047, 24'hA5A5A5, 2);
        draw(0, 4095, 3, 2, 24'h5A5A5A, 5);
        draw(2048, 2048, 1, 2047, 24'hFF0000, 2);
        draw(2047, 2047, 2047, 1, 24'h00FF00, 3);

        // Random part: mostly whole ellipses with random content, the rest
        // large abandoned ones, stray emit bursts and degenerate shapes.
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                a     = small_axis();
                b     = small_axis();
                emits = a + b + 1 + $urandom_range(0, 2);
                if ($urandom_range(0, 4) == 0)
                    emits = $urandom_range(0, emits);
                draw(COORD_BITS'($urandom), COORD_BITS'($urandom), AXIS_BITS'(a),
                     AXIS_BITS'(b), 24'($urandom), emits);
            end else if (kind < 85) begin
                draw(COORD_BITS'($urandom), COORD_BITS'($urandom),
                     AXIS_BITS'($urandom_range(0, 2047)), AXIS_BITS'($urandom_range(0, 2047)),
                     24'($urandom), $urandom_range(1, 8));
            end else if (kind < 95) begin
                repeat ($urandom_range(1, 4)) emit_word();
            end else if ($urandom_range(0, 1) == 0) begin
                b = $urandom_range(0, 20);
                draw(COORD_BITS'($urandom), COORD_BITS'($urandom), 0, AXIS_BITS'(b),
                     24'($urandom), b + 2);
            end else begin
                draw(COORD_BITS'($urandom), COORD_BITS'($urandom),
                     AXIS_BITS'($urandom_range(0, 2047)), 0, 24'($urandom), 2);
            end
        end
        in_valid <= 1'b0;

        // Drain: wait for every outstanding result, then allow for the
        // longest start-plus-region-change latency in case anything stray
        // is still on its way out.
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Run covered %0d input words: %0d point groups, %0d ellipses to the end,",
                 words_sent, groups_seen, ellipses_done);
        $display("and %0d idle replies, under random input gaps and output stalls.",
                 idle_seen);
        if (error_count == 0 && pending == 0)
            $display("midpoint_ellipse_raster_tb: clean");
        else
            $display("midpoint_ellipse_raster_tb: errors");
        $finish;
    end

    // Watchdog, well beyond the slowest legitimate run.
    initial begin
        #5000000;
        $display("midpoint_ellipse_raster_tb: errors");
        $finish;
    end

endmodule
